### sv/h2r_pkg.sv
`timescale 1ns / 1ps
package h2r_pkg;

    localparam int unsigned HUE_W       = 16;
    localparam int unsigned PCT_W       = 8;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned CLAMP_W     = 7;
    localparam int unsigned SEC_W       = 3;
    localparam int unsigned REM_W       = 6;
    localparam int unsigned K_W         = 13;
    localparam int unsigned DEG_W       = 9;
    localparam int unsigned Y_W         = 24;

    localparam int unsigned DEG_CIRCLE  = 360;
    localparam int unsigned SECTOR_DEG  = 60;
    localparam int unsigned PCT_MAX     = 100;
    localparam int unsigned K_FULL      = 6000;
    localparam int unsigned CH_SCALE    = 17;

    // floor(hue / 360) == (hue * HUE_RECIP) >> HUE_SHIFT for every 16-bit hue
    localparam int unsigned HUE_RECIP   = 46604;
    localparam int unsigned HUE_SHIFT   = 24;
    localparam int unsigned HUE_PROD_W  = 32;
    localparam int unsigned HUE_Q_W     = 8;

    // floor(y / 40000) == (y * CH_RECIP) >> CH_SHIFT for every y below 2**24
    localparam longint unsigned CH_RECIP = 64'd27487791;
    localparam int unsigned CH_SHIFT    = 40;
    localparam int unsigned CH_PROD_W   = 49;

    localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BM = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MR = 3'd5;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] value_level;
    } t_hsv;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [SEC_W-1:0]   sector;
        logic [REM_W-1:0]   rem;
        logic [CLAMP_W-1:0] sat;
        logic [CLAMP_W-1:0] val;
    } t_split;

    typedef struct packed {
        logic [SEC_W-1:0]   sector;
        logic [CLAMP_W-1:0] val;
        logic [K_W-1:0]     kp;
        logic [K_W-1:0]     kq;
        logic [K_W-1:0]     kt;
    } t_coef;

    typedef struct packed {
        logic en;
        logic vld;
    } t_stage_ctl;

endpackage

### sv/h2r_hue_split.sv
`timescale 1ns / 1ps
module h2r_hue_split (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  h2r_pkg::t_stage_ctl i_ctl,
    input  h2r_pkg::t_hsv  i_hsv,
    output logic           o_vld,
    output h2r_pkg::t_split o_split
);
    import h2r_pkg::*;

    logic [HUE_PROD_W-1:0] r_prod1;
    logic [HUE_W-1:0]      r_hue1;
    logic [CLAMP_W-1:0]    r_sat1, r_val1;
    logic                  r_vld1;

    logic [DEG_W-1:0]      r_h2;
    logic [CLAMP_W-1:0]    r_sat2, r_val2;
    logic                  r_vld2;

    t_split                r_split3;
    logic                  r_vld3;

    logic [HUE_Q_W-1:0]    w_q;
    logic [HUE_W-1:0]      w_h_full;
    t_split                n_split;

    assign w_q      = r_prod1[HUE_SHIFT +: HUE_Q_W];
    assign w_h_full = r_hue1 - HUE_W'(HUE_W'(w_q) * HUE_W'(DEG_CIRCLE));

    always_comb begin
        n_split.sat = r_sat2;
        n_split.val = r_val2;
        if (r_h2 < DEG_W'(SECTOR_DEG)) begin
            n_split.sector = SEC_RY;
            n_split.rem    = REM_W'(r_h2);
        end else if (r_h2 < DEG_W'(2 * SECTOR_DEG)) begin
            n_split.sector = SEC_YG;
            n_split.rem    = REM_W'(r_h2 - DEG_W'(SECTOR_DEG));
        end else if (r_h2 < DEG_W'(3 * SECTOR_DEG)) begin
            n_split.sector = SEC_GC;
            n_split.rem    = REM_W'(r_h2 - DEG_W'(2 * SECTOR_DEG));
        end else if (r_h2 < DEG_W'(4 * SECTOR_DEG)) begin
            n_split.sector = SEC_CB;
            n_split.rem    = REM_W'(r_h2 - DEG_W'(3 * SECTOR_DEG));
        end else if (r_h2 < DEG_W'(5 * SECTOR_DEG)) begin
            n_split.sector = SEC_BM;
            n_split.rem    = REM_W'(r_h2 - DEG_W'(4 * SECTOR_DEG));
        end else begin
            n_split.sector = SEC_MR;
            n_split.rem    = REM_W'(r_h2 - DEG_W'(5 * SECTOR_DEG));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld1 <= i_ctl.vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod1  <= HUE_PROD_W'(i_hsv.hue) * HUE_PROD_W'(HUE_RECIP);
            r_hue1   <= i_hsv.hue;
            r_sat1   <= (i_hsv.saturation > PCT_W'(PCT_MAX)) ? CLAMP_W'(PCT_MAX)
                                                             : i_hsv.saturation[CLAMP_W-1:0];
            r_val1   <= (i_hsv.value_level > PCT_W'(PCT_MAX)) ? CLAMP_W'(PCT_MAX)
                                                              : i_hsv.value_level[CLAMP_W-1:0];
            r_h2     <= w_h_full[DEG_W-1:0];
            r_sat2   <= r_sat1;
            r_val2   <= r_val1;
            r_split3 <= n_split;
        end
    end

    assign o_vld   = r_vld3;
    assign o_split = r_split3;

endmodule

### sv/h2r_coef.sv
`timescale 1ns / 1ps
module h2r_coef (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  h2r_pkg::t_stage_ctl i_ctl,
    input  h2r_pkg::t_split i_split,
    output logic            o_vld,
    output h2r_pkg::t_coef  o_coef
);
    import h2r_pkg::*;

    t_coef           r_coef;
    logic            r_vld;
    t_coef           n_coef;
    logic [K_W-1:0]  w_srem, w_sinv;

    assign w_srem = K_W'(i_split.sat) * K_W'(i_split.rem);
    assign w_sinv = K_W'(i_split.sat) * (K_W'(SECTOR_DEG) - K_W'(i_split.rem));

    always_comb begin
        n_coef.sector = i_split.sector;
        n_coef.val    = i_split.val;
        n_coef.kp     = K_W'(SECTOR_DEG) * (K_W'(PCT_MAX) - K_W'(i_split.sat));
        n_coef.kq     = K_W'(K_FULL) - w_srem;
        n_coef.kt     = K_W'(K_FULL) - w_sinv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_coef <= n_coef;
        end
    end

    assign o_vld  = r_vld;
    assign o_coef = r_coef;

endmodule

### sv/h2r_scale.sv
`timescale 1ns / 1ps
module h2r_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  h2r_pkg::t_stage_ctl i_ctl,
    input  h2r_pkg::t_coef i_coef,
    output logic           o_vld,
    output h2r_pkg::t_rgb  o_rgb
);
    import h2r_pkg::*;

    logic [K_W-1:0]       w_k [3];
    logic [Y_W-1:0]       w_x [3];
    logic [CH_PROD_W-1:0] w_p [3];
    logic [Y_W-1:0]       r_y [3];
    logic [CH_W-1:0]      r_ch [3];
    logic                 r_vld5, r_vld6;

    always_comb begin
        case (i_coef.sector)
            SEC_RY: begin
                w_k[0] = K_W'(K_FULL); w_k[1] = i_coef.kt; w_k[2] = i_coef.kp;
            end
            SEC_YG: begin
                w_k[0] = i_coef.kq; w_k[1] = K_W'(K_FULL); w_k[2] = i_coef.kp;
            end
            SEC_GC: begin
                w_k[0] = i_coef.kp; w_k[1] = K_W'(K_FULL); w_k[2] = i_coef.kt;
            end
            SEC_CB: begin
                w_k[0] = i_coef.kp; w_k[1] = i_coef.kq; w_k[2] = K_W'(K_FULL);
            end
            SEC_BM: begin
                w_k[0] = i_coef.kt; w_k[1] = i_coef.kp; w_k[2] = K_W'(K_FULL);
            end
            default: begin
                w_k[0] = K_W'(K_FULL); w_k[1] = i_coef.kp; w_k[2] = i_coef.kq;
            end
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign w_x[g] = Y_W'(i_coef.val) * Y_W'(w_k[g]);
        assign w_p[g] = CH_PROD_W'(r_y[g]) * CH_PROD_W'(CH_RECIP);

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_y[g]  <= Y_W'(CH_SCALE) * w_x[g];
                r_ch[g] <= w_p[g][CH_SHIFT +: CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld5 <= i_ctl.vld;
            r_vld6 <= r_vld5;
        end
    end

    assign o_vld       = r_vld6;
    assign o_rgb.red   = r_ch[0];
    assign o_rgb.green = r_ch[1];
    assign o_rgb.blue  = r_ch[2];

endmodule

### sv/hsv_to_rgb_converter_top.sv
// Each accepted input transaction runs through the hue split, coefficient and scale stages to its output transaction.
// Throughput: one transaction per cycle; all six stages advance together and hold
//   while the output transaction waits for i_out_ready.
// Reset: synchronous, active low on i_rst_n; clears every stage valid bit, data regs keep.
`timescale 1ns / 1ps
module hsv_to_rgb_converter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  h2r_pkg::t_hsv i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output h2r_pkg::t_rgb o_out_data
);
    import h2r_pkg::*;

    logic       w_adv;
    t_stage_ctl w_ctl_in, w_ctl_split, w_ctl_coef;
    t_split     w_split;
    t_coef      w_coef;
    logic       w_split_vld, w_coef_vld;

    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    assign w_ctl_in    = '{en: w_adv, vld: i_in_valid};
    assign w_ctl_split = '{en: w_adv, vld: w_split_vld};
    assign w_ctl_coef  = '{en: w_adv, vld: w_coef_vld};

    h2r_hue_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_in),
        .i_hsv   (i_in_data),
        .o_vld   (w_split_vld),
        .o_split (w_split)
    );

    h2r_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_split),
        .i_split (w_split),
        .o_vld   (w_coef_vld),
        .o_coef  (w_coef)
    );

    h2r_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_coef),
        .i_coef  (w_coef),
        .o_vld   (o_out_valid),
        .o_rgb   (o_out_data)
    );

    a_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_split_vld |-> (w_split.rem < REM_W'(SECTOR_DEG)) && (w_split.sector <= SEC_MR)
            && (w_split.sat <= CLAMP_W'(PCT_MAX)) && (w_split.val <= CLAMP_W'(PCT_MAX)))
        else $error("hue split out of range");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_coef_vld |-> (w_coef.kp <= K_W'(K_FULL)) && (w_coef.kq <= K_W'(K_FULL))
            && (w_coef.kt <= K_W'(K_FULL)))
        else $error("coefficient above full scale");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !w_split_vld && !w_coef_vld)
        else $error("pipeline valid after reset");

endmodule
